### rtl/core/ephemeral_port_bitmap_allocator_assert.svh
// Assertion macros shared by the allocator's controller and datapath.
// Each macro expects a signal named clk, and EPBA_ASSERT also rst_n, in the scope where it is used.
`ifndef EPHEMERAL_PORT_BITMAP_ALLOCATOR_ASSERT_SVH
`define EPHEMERAL_PORT_BITMAP_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
// Checked only while out of reset.
`define EPBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define EPBA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define EPBA_ASSERT(lbl, prop, msg)
`define EPBA_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### rtl/core/epba_pkg.sv
// Shared types and constants of the ephemeral port bitmap allocator.
// No dependencies; used by epba_ctrl, epba_dp and the top level.
package epba_pkg;

  localparam int PortW        = 16;
  localparam int OffW         = 7;
  localparam int LowFreePorts = 8;
  localparam logic [PortW-1:0] StartReset = 16'd49152;

  typedef logic [PortW-1:0] port_t;

  typedef enum logic [1:0] {
    OP_QUERY = 2'd0,
    OP_FREE  = 2'd1,
    OP_MARK  = 2'd2,
    OP_ALLOC = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_EXHAUSTED = 2'd1,
    STAT_BAD_FREE  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ACCESS,
    S_SEED,
    S_BEGIN1,
    S_SCAN1,
    S_BEGIN2,
    S_SCAN2,
    S_RESP
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_step;
    logic in_load;
    logic finish_port;
    logic seed;
    logic begin_scan;
    logic phase2;
    logic advance;
    logic finish_hit;
    logic finish_none;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller. empty1 and empty2 flag an
  // empty upward window and an empty wrapped window.
  typedef struct packed {
    logic clr_last;
    logic op_alloc;
    logic empty1;
    logic empty2;
    logic hit;
    logic at_last;
  } sts_t;

endpackage

### rtl/core/epba_ctrl.sv
// Controller of the ephemeral port bitmap allocator: sequences clearing,
// port operations and the allocation scan. Depends on epba_pkg.
`include "ephemeral_port_bitmap_allocator_assert.svh"

module epba_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  epba_pkg::sts_t sts,
  output epba_pkg::cmd_t cmd
);
  import epba_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.in_load = 1'b1;
          state_nxt   = sts.op_alloc ? S_SEED : S_ACCESS;
        end
      end
      S_ACCESS: begin
        cmd.finish_port = 1'b1;
        state_nxt       = S_RESP;
      end
      S_SEED: begin
        cmd.seed  = 1'b1;
        state_nxt = S_BEGIN1;
      end
      S_BEGIN1: begin
        cmd.begin_scan = 1'b1;
        state_nxt      = sts.empty1 ? S_BEGIN2 : S_SCAN1;
      end
      S_SCAN1: begin
        if (sts.hit) begin
          cmd.finish_hit = 1'b1;
          state_nxt      = S_RESP;
        end else if (sts.at_last) begin
          state_nxt = S_BEGIN2;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      S_BEGIN2: begin
        cmd.begin_scan = 1'b1;
        cmd.phase2     = 1'b1;
        if (sts.empty2) begin
          cmd.finish_none = 1'b1;
          state_nxt       = S_RESP;
        end else begin
          state_nxt = S_SCAN2;
        end
      end
      S_SCAN2: begin
        if (sts.hit) begin
          cmd.finish_hit = 1'b1;
          state_nxt      = S_RESP;
        end else if (sts.at_last) begin
          cmd.finish_none = 1'b1;
          state_nxt       = S_RESP;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

  `EPBA_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> (state_r == S_CLEAR), "reset did not restart the clearing pass")
  `EPBA_ASSERT(a_accept_starts, (in_valid && in_ready) |=> (state_r == S_ACCESS || state_r == S_SEED), "accepted word did not start an operation")
  `EPBA_ASSERT(a_scan_continues, ((state_r == S_SCAN1 || state_r == S_SCAN2) && !sts.hit && !sts.at_last) |=> (state_r == $past(state_r)), "scan stopped before its last word")

endmodule

### rtl/core/epba_dp.sv
// Datapath of the ephemeral port bitmap allocator: bitmap memory, next-fit
// pointer, scan window logic and result registers. Depends on epba_pkg.
`include "ephemeral_port_bitmap_allocator_assert.svh"

module epba_dp #(
  parameter int NUM_PORTS = 65536,
  parameter int WORD_BITS = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  epba_pkg::cmd_t        cmd,
  output epba_pkg::sts_t        sts,
  input  logic                  cfg_we,
  input  logic [15:0]           cfg_ephemeral_start,
  input  logic [1:0]            in_op,
  input  logic [15:0]           in_port,
  input  logic [6:0]            in_random_offset,
  output logic [15:0]           out_port_out,
  output logic                  out_answer,
  output logic [1:0]            out_status
);
  import epba_pkg::*;

  localparam int MapWords = (NUM_PORTS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW       = $clog2(MapWords);
  localparam int BW       = $clog2(WORD_BITS);
  localparam int ExtW     = PortW + 1;
  localparam logic [ExtW-1:0] NumPortsV = ExtW'(NUM_PORTS);

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [AW-1:0]        waddr_t;
  typedef logic [BW-1:0]        bidx_t;

  localparam word_t  LowWord  = WORD_BITS'(8'hFF);
  localparam waddr_t LastAddr = AW'(MapWords - 1);
  localparam bidx_t  TopBit   = BW'(WORD_BITS - 1);

  word_t mem [MapWords];

  op_t              op_r;
  port_t            port_r;
  logic [OffW-1:0]  off_r;
  port_t            start_r;
  port_t            last_r;
  port_t            lp_r;
  waddr_t           cur_w_r;
  waddr_t           end_w_r;
  bidx_t            lo_bit_r;
  bidx_t            hi_bit_r;
  logic             first_r;
  waddr_t           clr_w_r;
  word_t            rd_data_r;
  port_t            res_port_r;
  logic             res_answer_r;
  status_t          res_status_r;
  port_t            out_port_r;
  logic             out_answer_r;
  status_t          out_status_r;

  logic             mem_we;
  waddr_t           mem_wa;
  word_t            mem_wd;
  waddr_t           rd_addr;

  port_t            lp_inc;
  logic [ExtW-1:0]  seed_sum;
  port_t            lp_seed;
  port_t            lp_nxt;
  logic [ExtW-1:0]  hi2;
  logic [ExtW-1:0]  lo_v;
  logic [ExtW-1:0]  hi_v;
  logic [ExtW-1:0]  hi_m1;
  waddr_t           first_w;
  waddr_t           end_w;

  word_t            lo_mask;
  word_t            hi_mask;
  word_t            cand;
  bidx_t            hit_bit;
  logic             at_last;

  logic             in_range;
  bidx_t            pbit_idx;
  logic             cur_bit;
  word_t            pmask;
  logic             bad_free;
  logic             mark_new;
  port_t            hit_port;

  // Pointer advance and re-seed.
  always_comb begin
    lp_inc   = port_t'(last_r + 1'b1);
    seed_sum = {1'b0, start_r} + ExtW'(off_r);
    lp_seed  = seed_sum[PortW] ? start_r : seed_sum[PortW-1:0];
    lp_nxt   = (lp_inc < start_r) ? lp_seed : lp_inc;
  end

  // Upper bound of the wrapped window; it depends on registers only.
  assign hi2 = ({1'b0, lp_r} < NumPortsV) ? {1'b0, lp_r} : NumPortsV;

  // Window bounds of the current scan phase.
  always_comb begin
    lo_v    = cmd.phase2 ? {1'b0, start_r} : {1'b0, lp_r};
    hi_v    = cmd.phase2 ? hi2 : NumPortsV;
    hi_m1   = hi_v - 1'b1;
    first_w = AW'(lo_v >> BW);
    end_w   = AW'(hi_m1 >> BW);
  end

  // Clear bits of the current word inside the window.
  always_comb begin
    at_last = (cur_w_r == end_w_r);
    lo_mask = first_r ? ({WORD_BITS{1'b1}} << lo_bit_r) : {WORD_BITS{1'b1}};
    hi_mask = at_last ? ({WORD_BITS{1'b1}} >> (TopBit - hi_bit_r)) : {WORD_BITS{1'b1}};
    cand    = ~rd_data_r & lo_mask & hi_mask;
  end

  always_comb begin
    hit_bit = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (cand[i]) begin
        hit_bit = BW'(i);
      end
    end
  end

  assign hit_port = port_t'({cur_w_r, hit_bit});

  // Single-port operations on the word read at accept.
  always_comb begin
    in_range = ({1'b0, port_r} < NumPortsV);
    pbit_idx = port_r[BW-1:0];
    cur_bit  = rd_data_r[pbit_idx] & in_range;
    pmask    = word_t'(1) << pbit_idx;
    bad_free = (port_r == '0) || !cur_bit;
    mark_new = in_range && !cur_bit;
  end

  // Memory write and read address selection.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = cur_w_r;
    mem_wd = rd_data_r | (word_t'(1) << hit_bit);
    if (cmd.clr_step) begin
      mem_we = 1'b1;
      mem_wa = clr_w_r;
      mem_wd = (clr_w_r == '0) ? LowWord : '0;
    end else if (cmd.finish_port) begin
      mem_wa = AW'(port_r >> BW);
      case (op_r)
        OP_FREE: begin
          mem_we = !bad_free;
          mem_wd = rd_data_r & ~pmask;
        end
        OP_MARK: begin
          mem_we = mark_new;
          mem_wd = rd_data_r | pmask;
        end
        default: begin
          mem_we = 1'b0;
        end
      endcase
    end else if (cmd.finish_hit) begin
      mem_we = 1'b1;
    end
  end

  always_comb begin
    if (cmd.in_load) begin
      rd_addr = AW'(in_port >> BW);
    end else if (cmd.begin_scan) begin
      rd_addr = first_w;
    end else if (cmd.advance) begin
      rd_addr = cur_w_r + 1'b1;
    end else begin
      rd_addr = cur_w_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Control state: configuration, pointer and clearing counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= StartReset;
      last_r  <= '0;
      clr_w_r <= '0;
    end else begin
      if (cfg_we) begin
        start_r <= cfg_ephemeral_start;
      end
      if (cmd.seed) begin
        last_r <= lp_nxt;
      end else if (cmd.finish_hit) begin
        last_r <= hit_port;
      end
      if (cmd.clr_step) begin
        clr_w_r <= clr_w_r + 1'b1;
      end
    end
  end

  // Operand, scan and result registers.
  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      op_r   <= op_t'(in_op);
      port_r <= in_port;
      off_r  <= in_random_offset;
    end
    if (cmd.seed) begin
      lp_r <= lp_nxt;
    end
    if (cmd.begin_scan) begin
      cur_w_r  <= first_w;
      end_w_r  <= end_w;
      lo_bit_r <= lo_v[BW-1:0];
      hi_bit_r <= hi_m1[BW-1:0];
      first_r  <= 1'b1;
    end else if (cmd.advance) begin
      cur_w_r <= cur_w_r + 1'b1;
      first_r <= 1'b0;
    end
    if (cmd.finish_port) begin
      res_port_r   <= port_r;
      res_status_r <= STAT_OK;
      case (op_r)
        OP_QUERY: res_answer_r <= cur_bit && (port_r >= PortW'(LowFreePorts));
        OP_FREE: begin
          res_answer_r <= !bad_free;
          res_status_r <= bad_free ? STAT_BAD_FREE : STAT_OK;
        end
        OP_MARK:  res_answer_r <= mark_new;
        default:  res_answer_r <= 1'b0;
      endcase
    end else if (cmd.finish_hit) begin
      res_port_r   <= hit_port;
      res_answer_r <= 1'b1;
      res_status_r <= STAT_OK;
    end else if (cmd.finish_none) begin
      res_port_r   <= '0;
      res_answer_r <= 1'b0;
      res_status_r <= STAT_EXHAUSTED;
    end
    if (cmd.out_load) begin
      out_port_r   <= res_port_r;
      out_answer_r <= res_answer_r;
      out_status_r <= res_status_r;
    end
  end

  always_comb begin
    sts.clr_last = (clr_w_r == LastAddr);
    sts.op_alloc = (op_t'(in_op) == OP_ALLOC);
    sts.empty1   = ({1'b0, lp_r} >= NumPortsV);
    sts.empty2   = ({1'b0, start_r} >= hi2);
    sts.hit      = |cand;
    sts.at_last  = at_last;
  end

  assign out_port_out = out_port_r;
  assign out_answer   = out_answer_r;
  assign out_status   = out_status_r;

  `EPBA_ASSERT(a_hit_sets_clear_bit, cmd.finish_hit |-> (mem_wd != rd_data_r), "allocated bit was already set")
  `EPBA_ASSERT(a_hit_moves_pointer, cmd.finish_hit |=> (last_r == res_port_r), "pointer does not follow the allocated port")

endmodule

### rtl/core/ephemeral_port_bitmap_allocator.sv
// Top level of the ephemeral port bitmap allocator.
// Instantiates epba_ctrl and epba_dp; uses epba_pkg.

// Next-fit port allocator over a one-bit-per-port used map held in a single
// memory of NUM_PORTS / WORD_BITS words, rounded up. Each input word carries one
// operation (query, free, mark, allocate) and yields exactly one result word.
// After reset the block runs a clearing pass over every map word that writes
// ports 0 to 7 as used and all others as free; in_ready stays low during the
// pass, while configuration writes are taken at any time. Query, free and mark
// make one registered memory read and one read-modify-write before the result
// is loaded. Allocate scans the map word by word, because the memory port reads
// one word per cycle; when the scan wraps from the top of the map back to the
// ephemeral start it passes through a state that sets up the second window.
// The block works on one item at a time, but a finished result sits in an output
// register so the next word is accepted while the previous result waits for
// out_ready. The single configuration register, the ephemeral start port, is
// written through the cfg channel whose ready is always high; write it only
// while the block is idle.
// WORD_BITS must be a power of two; NUM_PORTS may be any value in its range.
module ephemeral_port_bitmap_allocator #(
  parameter int NUM_PORTS = 65536,
  parameter int WORD_BITS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_ephemeral_start,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [15:0] in_port,
  input  logic [6:0]  in_random_offset,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_port_out,
  output logic        out_answer,
  output logic [1:0]  out_status
);
  import epba_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // The start register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  epba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  epba_dp #(
    .NUM_PORTS (NUM_PORTS),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .cfg_we              (cfg_valid && cfg_ready),
    .cfg_ephemeral_start (cfg_ephemeral_start),
    .in_op               (in_op),
    .in_port             (in_port),
    .in_random_offset    (in_random_offset),
    .out_port_out        (out_port_out),
    .out_answer          (out_answer),
    .out_status          (out_status)
  );

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the ephemeral port bitmap allocator top level.
// Depends on epba_pkg and ephemeral_port_bitmap_allocator; it has no other inputs.

module testbench;
  import epba_pkg::*;

  // The map size must match the parameter that is passed to the block below.
  localparam int MapPorts = 65536;
  localparam int MapWordBits = 64;
  // Full cycles, not nanoseconds. The slowest correct run is roughly the clearing pass,
  // plus 1150 words that each wait out the longest send gap and the longest read stall, plus
  // a short map scan, so this limit has a wide margin.
  localparam int unsigned CycleLimit = 600000;
  // An allocate scans a few map words at most in this run, so the drain wait is long enough
  // to see any stray result after the last expected one.
  localparam int unsigned DrainCycles = 40;

  // One input word as the sender queues it.
  typedef struct {
    op_t              op;
    port_t            port;
    logic [OffW-1:0]  offset;
  } port_request_t;

  // One result word as the allocator should return it.
  typedef struct {
    port_t   port_out;
    logic    answer;
    status_t status;
  } port_reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_ephemeral_start = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_op = OP_QUERY;
  logic [15:0] in_port = '0;
  logic [6:0]  in_random_offset = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_port_out;
  logic        out_answer;
  logic [1:0]  out_status;

  // Shadow copy of the allocator state: one used bit per port, the next-fit pointer and
  // the ephemeral start register. It is updated in the order in which words are accepted.
  bit    port_used [MapPorts];
  port_t next_fit_ptr = '0;
  port_t ephemeral_base = StartReset;

  port_request_t port_requests[$];
  port_reply_t   due_replies[$];
  port_reply_t   seen_reply;

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned pattern_age = 0;
  logic [7:0]  ready_pattern = 8'hFF;

  ephemeral_port_bitmap_allocator #(
    .NUM_PORTS(MapPorts),
    .WORD_BITS(MapWordBits)
  ) u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_ephemeral_start(cfg_ephemeral_start),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_op              (in_op),
    .in_port            (in_port),
    .in_random_offset   (in_random_offset),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_port_out       (out_port_out),
    .out_answer         (out_answer),
    .out_status         (out_status)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Applies one operation to the shadow state and returns the result word it must produce.
  function automatic port_reply_t apply_port_op(input port_request_t req);
    port_reply_t reply;
    int unsigned ptr;
    int unsigned seed;
    int unsigned lim;
    int unsigned cand;
    int unsigned hit_port;
    bit          hit;
    reply.port_out = req.port;
    reply.answer = 1'b0;
    reply.status = STAT_OK;
    hit = 1'b0;
    hit_port = 0;
    case (req.op)
      OP_QUERY: begin
        // The reserved low ports always read as free, whatever their bit holds.
        reply.answer = (req.port >= LowFreePorts) && port_used[req.port];
      end
      OP_FREE: begin
        // Port zero can never be freed. Freeing a port that is not in use is an error
        // too, and it leaves the map alone.
        if (req.port == 0 || !port_used[req.port]) begin
          reply.status = STAT_BAD_FREE;
        end else begin
          port_used[req.port] = 1'b0;
          reply.answer = 1'b1;
        end
      end
      OP_MARK: begin
        if (!port_used[req.port]) begin
          port_used[req.port] = 1'b1;
          reply.answer = 1'b1;
        end
      end
      default: begin
        // Step the pointer. If it wraps or falls below the start, seed it at start plus
        // the offset. If that sum would not fit in 16 bits, seed it at the start alone.
        ptr = (32'(next_fit_ptr) + 1) & 32'hFFFF;
        if (ptr < ephemeral_base) begin
          seed = ephemeral_base + req.offset;
          ptr = (seed > 32'hFFFF) ? 32'(ephemeral_base) : seed;
        end
        next_fit_ptr = port_t'(ptr);
        // First search from the pointer to the top of the map. Then search from the start
        // up to the pointer.
        for (cand = ptr; cand < MapPorts && !hit; cand++) begin
          if (!port_used[cand]) begin
            hit = 1'b1;
            hit_port = cand;
          end
        end
        lim = (ptr < MapPorts) ? ptr : MapPorts;
        for (cand = ephemeral_base; cand < lim && !hit; cand++) begin
          if (!port_used[cand]) begin
            hit = 1'b1;
            hit_port = cand;
          end
        end
        if (hit) begin
          port_used[hit_port] = 1'b1;
          next_fit_ptr = port_t'(hit_port);
          reply.port_out = port_t'(hit_port);
          reply.answer = 1'b1;
        end else begin
          // When no port is free, the pointer keeps the stepped or seeded value.
          reply.port_out = '0;
          reply.status = STAT_EXHAUSTED;
        end
      end
    endcase
    return reply;
  endfunction

  task automatic add_request(input op_t op, input port_t port, input logic [OffW-1:0] offset);
    port_request_t req;
    req.op = op;
    req.port = port;
    req.offset = offset;
    port_requests.push_back(req);
  endtask

  // Random traffic for one setting of the start port. Most ports land in a window just
  // above the start, so frees and marks hit ports that allocation has handed out. The rest
  // are spread over the whole range, the reserved low ports and the top of the map.
  task automatic add_random_requests(input port_t base, input int unsigned count,
                                     input int unsigned alloc_pct);
    int unsigned roll;
    int unsigned top;
    op_t         op;
    port_t       port;
    top = (base + 300 > 65535) ? 65535 : base + 300;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < alloc_pct) begin
        op = OP_ALLOC;
      end else if (roll < alloc_pct + (100 - alloc_pct) / 3) begin
        op = OP_FREE;
      end else if (roll < alloc_pct + 2 * (100 - alloc_pct) / 3) begin
        op = OP_MARK;
      end else begin
        op = OP_QUERY;
      end
      case ($urandom_range(0, 9))
        6, 7: port = port_t'($urandom);
        8: port = port_t'($urandom_range(0, 15));
        9: port = port_t'($urandom_range(65520, 65535));
        default: port = port_t'($urandom_range(base, top));
      endcase
      add_request(op, port, 7'($urandom_range(0, 127)));
    end
  endtask

  // The check runs at the falling edge, so that all the work of the rising edge has settled.
  task automatic wait_until_idle();
    do @(negedge clk); while (port_requests.size() != 0 || in_valid || due_replies.size() != 0);
  endtask

  // Call this only while the block is idle. The shadow start changes at the handshake.
  task automatic write_ephemeral_start(input port_t value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_ephemeral_start <= value;
    do @(posedge clk); while (!cfg_ready);
    ephemeral_base = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic flag_mismatch(input string msg);
    error_count++;
    if (error_count <= 10) begin
      $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    end
  endtask

  // Sender. It sends words in bursts of random length with random gaps between them. A
  // word that has not been accepted stays on the port unchanged, with valid held high.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        due_replies.push_back(apply_port_op('{op_t'(in_op), in_port, in_random_offset}));
      end
      if (in_valid && !in_ready) begin
        // Hold the current word.
      end else if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (port_requests.size() != 0) begin
        in_valid <= 1'b1;
        in_op <= port_requests[0].op;
        in_port <= port_requests[0].port;
        in_random_offset <= port_requests[0].offset;
        void'(port_requests.pop_front());
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 48);
          // Now and then no gap at all, so that two bursts run together.
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver. It stalls by a rotating eight bit pattern that is picked again whenever its
  // age counter runs out. The patterns are always ready, a random mix, or a single ready slot.
  // A pattern never has zero ready bits, so every rotation of it gives a ready slot.
  always @(posedge clk) begin
    if (pattern_age == 0) begin
      case ($urandom_range(0, 3))
        0: ready_pattern = 8'hFF;
        1: ready_pattern = 8'($urandom) | 8'h01;
        2: ready_pattern = 8'h01 << $urandom_range(0, 7);
        default: ready_pattern = 8'($urandom) | 8'h81;
      endcase
      pattern_age = $urandom_range(16, 300);
    end else begin
      pattern_age = pattern_age - 1;
    end
    out_ready <= ready_pattern[0];
    ready_pattern = {ready_pattern[0], ready_pattern[7:1]};
  end

  // Checker. Each result word must match the oldest prediction in every field.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (due_replies.size() == 0) begin
        flag_mismatch($sformatf("result with none expected: port_out %0d answer %0b status %0d",
                                out_port_out, out_answer, out_status));
      end else begin
        seen_reply = due_replies.pop_front();
        if (out_port_out !== seen_reply.port_out || out_answer !== seen_reply.answer ||
            out_status !== seen_reply.status) begin
          flag_mismatch($sformatf(
            "expected port_out %0d answer %0b status %0d, got port_out %0d answer %0b status %0d",
            seen_reply.port_out, seen_reply.answer, seen_reply.status,
            out_port_out, out_answer, out_status));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : run_sequence
    port_t       base;
    int unsigned count;
    int unsigned alloc_pct;
    int unsigned phase;
    // After reset the reserved low ports are marked used.
    for (int p = 0; p < LowFreePorts; p++) begin
      port_used[p] = 1'b1;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed words with the reset start value. They cover the reserved low ports, port
    // zero, the top port, a repeated mark, frees of used and of unused ports, and a seed
    // with the largest offset.
    add_request(OP_QUERY, 16'd0, 7'd0);
    add_request(OP_QUERY, 16'd7, 7'd0);
    add_request(OP_FREE, 16'd0, 7'd0);
    add_request(OP_FREE, 16'd5, 7'd0);
    add_request(OP_MARK, 16'd5, 7'd0);
    add_request(OP_QUERY, 16'hFFFF, 7'd0);
    add_request(OP_MARK, 16'hFFFF, 7'd0);
    add_request(OP_MARK, 16'hFFFF, 7'd0);
    add_request(OP_QUERY, 16'hFFFF, 7'd127);
    add_request(OP_FREE, 16'd300, 7'd0);
    add_request(OP_ALLOC, 16'd0, 7'd127);
    add_request(OP_ALLOC, 16'hFFFF, 7'd0);
    add_request(OP_FREE, 16'd49279, 7'd0);
    add_request(OP_QUERY, 16'd8, 7'd0);

    // With the start at the top port, a seed overflows and falls back to the start alone.
    // The top port is marked, so allocation finds the map exhausted. After a free it
    // succeeds once, and then it is exhausted again.
    wait_until_idle();
    write_ephemeral_start(16'hFFFF);
    @(negedge clk);
    add_request(OP_ALLOC, 16'h5555, 7'd127);
    add_request(OP_FREE, 16'hFFFF, 7'd0);
    add_request(OP_ALLOC, 16'hAAAA, 7'd0);
    add_request(OP_ALLOC, 16'd0, 7'd5);
    add_request(OP_MARK, 16'hFFFE, 7'd0);

    // With the start at one, allocation must step past the reserved low ports.
    wait_until_idle();
    write_ephemeral_start(16'd1);
    @(negedge clk);
    add_request(OP_ALLOC, 16'd0, 7'd0);
    add_request(OP_ALLOC, 16'd0, 7'd127);
    add_request(OP_FREE, 16'd8, 7'd0);
    add_request(OP_QUERY, 16'd8, 7'd0);

    // Random phases, each at its own start setting. The starts at 65472 and 65408 leave
    // only 64 and 128 ports and carry more allocates, so they run into exhaustion and
    // wrapped searches.
    for (phase = 0; phase < 8; phase++) begin
      alloc_pct = 40;
      count = 130;
      case (phase)
        0: begin base = StartReset; count = 150; end
        1: begin base = 16'd65472; count = 150; alloc_pct = 60; end
        2: begin base = 16'd1; count = 140; end
        3: begin base = 16'd30000; count = 150; end
        4: begin base = 16'hFFFF; count = 100; end
        5: base = port_t'($urandom_range(1, 65535));
        6: begin base = 16'd65408; count = 170; alloc_pct = 65; end
        default: base = 16'd1024;
      endcase
      wait_until_idle();
      write_ephemeral_start(base);
      @(negedge clk);
      add_random_requests(base, count, alloc_pct);
    end

    wait_until_idle();
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0 && due_replies.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
